FILE: hdl/page_framebuffer_blit_flush_unit_defines.svh
// assertion macros for the page framebuffer blit and flush unit
`ifndef PAGE_FRAMEBUFFER_BLIT_FLUSH_UNIT_DEFINES_SVH
`define PAGE_FRAMEBUFFER_BLIT_FLUSH_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define PFB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define PFB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/pfb_pkg.sv
// types and constants of the page framebuffer blit and flush unit
package pfb_pkg;

  localparam int COLUMNS     = 128;
  localparam int ROWS        = 32;
  localparam int PAGES       = (ROWS + 7) / 8;
  localparam int STORE_BYTES = PAGES * COLUMNS;
  localparam int HEADER_LEN  = 3;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam int PAGE_W      = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int POS_W       = $clog2(COLUMNS + HEADER_LEN);
  localparam int MAP_X_W     = 9;
  localparam int BITS_PER_BEAT = 8;

  localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
  localparam logic [7:0] CMD_COL_LOW   = 8'h04;
  localparam logic [7:0] CMD_COL_HIGH  = 8'h10;

  typedef enum logic [1:0] {
    FN_CLEAR = 2'd0,
    FN_PIXEL = 2'd1,
    FN_BLIT  = 2'd2,
    FN_FLUSH = 2'd3
  } func_t;

  typedef struct packed {
    logic              ok;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        mask;
  } pix_loc_t;

endpackage

FILE: hdl/pfb_if.sv
// handshake channels of the page framebuffer blit and flush unit
interface pfb_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] pos_x;
  logic [7:0] pos_y;
  logic       color;
  logic [7:0] pattern;
  logic [3:0] bit_count;

  modport source (output valid, func, pos_x, pos_y, color, pattern, bit_count,
                  input ready);
  modport sink (input valid, func, pos_x, pos_y, color, pattern, bit_count,
                output ready);
endinterface

interface pfb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_data;
  logic       frame_end;

  modport source (output valid, out_byte, is_data, frame_end, input ready);
  modport sink (input valid, out_byte, is_data, frame_end, output ready);
endinterface

FILE: hdl/pfb_pixel_map.sv
// maps a column and row to a store byte address and bit mask
module pfb_pixel_map (
  input  logic [pfb_pkg::MAP_X_W-1:0] px,
  input  logic [7:0]                  py,
  output pfb_pkg::pix_loc_t           loc
);

  logic [31:0] lin;

  always_comb begin
    lin = 32'(py[7:3]) * 32'(pfb_pkg::COLUMNS) + 32'(px);
    loc.ok   = (32'(px) < 32'(pfb_pkg::COLUMNS)) && (32'(py) < 32'(pfb_pkg::ROWS));
    loc.addr = lin[pfb_pkg::ADDR_W-1:0];
    loc.mask = 8'd1 << py[2:0];
  end

endmodule

FILE: hdl/page_framebuffer_blit_flush_unit.sv
// top level of the page framebuffer blit and flush unit
// one item at a time; ready only when idle, a finished result may wait in the output register
// pixel: one store read-modify-write step; bitmap byte: one such step per source bit, then a tail step
// flush step: a command byte goes straight to the result, a data byte waits for one registered store read
// clear: walks all STORE_BYTES store bytes (512 by default), one store byte zeroed per cycle
// reset (rst_n low, synchronous) starts the same walk: no item is taken until the walk ends
`include "page_framebuffer_blit_flush_unit_defines.svh"

module page_framebuffer_blit_flush_unit (
  input  logic      clk,
  input  logic      rst_n,
  pfb_in_if.sink    in_bus,
  pfb_out_if.source out_bus
);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_RMW   = 7'b0000100,
    S_TAIL  = 7'b0001000,
    S_FLUSH = 7'b0010000,
    S_FWAIT = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  localparam int AW = pfb_pkg::ADDR_W;
  localparam int PW = pfb_pkg::PAGE_W;
  localparam int QW = pfb_pkg::POS_W;
  localparam int XW = pfb_pkg::MAP_X_W;

  state_t         state_r, state_nxt;
  logic [2:0]     step_r, step_nxt;
  logic [AW-1:0]  clr_addr_r, clr_addr_nxt;
  logic           clr_item_r, clr_item_nxt;
  logic           pend_en_r, pend_en_nxt;
  logic [PW-1:0]  page_r, page_nxt;
  logic [QW-1:0]  pos_r, pos_nxt;
  logic           out_valid_r, out_valid_nxt;

  pfb_pkg::func_t func_r;
  logic [7:0]     x_r, y_r, pat_r;
  logic           color_r;
  logic [3:0]     cnt_r;
  logic [AW-1:0]  pend_addr_r;
  logic [7:0]     pend_mask_r;
  logic           pend_set_r;
  logic [7:0]     res_byte_r, res_byte_nxt;
  logic           res_data_r, res_data_nxt;
  logic           res_end_r, res_end_nxt;
  logic [7:0]     out_byte_r;
  logic           out_data_r, out_end_r;
  logic [7:0]     rdata_r;

  logic [7:0]     mem [pfb_pkg::STORE_BYTES];

  logic [XW-1:0]     map_x;
  logic [7:0]        map_y;
  pfb_pkg::pix_loc_t loc;

  logic              accept, load_out, bit_on, last_step;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [7:0]        wr_data;

  assign accept   = in_bus.valid && in_bus.ready;
  assign load_out = (state_r == S_DONE) && (!out_valid_r || out_bus.ready);

  assign in_bus.ready      = (state_r == S_IDLE);
  assign out_bus.valid     = out_valid_r;
  assign out_bus.out_byte  = out_byte_r;
  assign out_bus.is_data   = out_data_r;
  assign out_bus.frame_end = out_end_r;

  // shared address unit: bitmap/pixel position or flush column
  always_comb begin
    if (state_r == S_FLUSH) begin
      map_x = XW'(pos_r - QW'(pfb_pkg::HEADER_LEN));
      map_y = 8'({page_r, 3'b000});
    end else begin
      map_x = XW'(x_r) + XW'(step_r);
      map_y = y_r;
    end
  end

  pfb_pixel_map u_map (
    .px  (map_x),
    .py  (map_y),
    .loc (loc)
  );

  always_comb begin
    bit_on    = (func_r == pfb_pkg::FN_PIXEL) ||
                (pat_r[3'd7 - step_r] && ({1'b0, step_r} < cnt_r));
    last_step = (func_r == pfb_pkg::FN_PIXEL) || (step_r == 3'd7);
  end

  // store write port: clear walk or pending read-modify-write
  always_comb begin
    if (state_r == S_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr_r;
      wr_data = 8'h00;
    end else begin
      wr_en   = pend_en_r;
      wr_addr = pend_addr_r;
      wr_data = pend_set_r ? (rdata_r | pend_mask_r) : (rdata_r & ~pend_mask_r);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_r <= mem[loc.addr];
  end

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    clr_addr_nxt  = clr_addr_r;
    clr_item_nxt  = clr_item_r;
    pend_en_nxt   = 1'b0;
    page_nxt      = page_r;
    pos_nxt       = pos_r;
    res_byte_nxt  = res_byte_r;
    res_data_nxt  = res_data_r;
    res_end_nxt   = res_end_r;
    out_valid_nxt = (out_valid_r && !out_bus.ready) || load_out;
    case (state_r)
      S_CLEAR: begin
        clr_addr_nxt = clr_addr_r + AW'(1);
        if (clr_addr_r == AW'(pfb_pkg::STORE_BYTES - 1)) begin
          clr_addr_nxt = '0;
          state_nxt    = clr_item_r ? S_DONE : S_IDLE;
          res_byte_nxt = 8'h00;
          res_data_nxt = 1'b0;
          res_end_nxt  = 1'b0;
        end
      end
      S_IDLE: begin
        if (accept) begin
          step_nxt = '0;
          case (pfb_pkg::func_t'(in_bus.func))
            pfb_pkg::FN_CLEAR: begin
              clr_item_nxt = 1'b1;
              state_nxt    = S_CLEAR;
            end
            pfb_pkg::FN_PIXEL: state_nxt = S_RMW;
            pfb_pkg::FN_BLIT:  state_nxt = S_RMW;
            pfb_pkg::FN_FLUSH: state_nxt = S_FLUSH;
            default:           state_nxt = S_IDLE;
          endcase
        end
      end
      S_RMW: begin
        pend_en_nxt = loc.ok && bit_on;
        step_nxt    = step_r + 3'd1;
        if (last_step) begin
          state_nxt = S_TAIL;
        end
      end
      S_TAIL: begin
        res_byte_nxt = 8'h00;
        res_data_nxt = 1'b0;
        res_end_nxt  = 1'b0;
        state_nxt    = S_DONE;
      end
      S_FLUSH: begin
        res_end_nxt = 1'b0;
        pos_nxt     = pos_r + QW'(1);
        if (pos_r == QW'(pfb_pkg::HEADER_LEN + pfb_pkg::COLUMNS - 1)) begin
          pos_nxt  = '0;
          page_nxt = page_r + PW'(1);
          if (page_r == PW'(pfb_pkg::PAGES - 1)) begin
            page_nxt    = '0;
            res_end_nxt = 1'b1;
          end
        end
        res_data_nxt = 1'b0;
        state_nxt    = S_DONE;
        if (pos_r == QW'(0)) begin
          res_byte_nxt = pfb_pkg::CMD_PAGE_BASE + 8'(page_r);
        end else if (pos_r == QW'(1)) begin
          res_byte_nxt = pfb_pkg::CMD_COL_LOW;
        end else if (pos_r == QW'(2)) begin
          res_byte_nxt = pfb_pkg::CMD_COL_HIGH;
        end else begin
          res_data_nxt = 1'b1;
          state_nxt    = S_FWAIT;
        end
      end
      S_FWAIT: begin
        res_byte_nxt = rdata_r;
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        clr_item_nxt = 1'b0;
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      step_r      <= '0;
      clr_addr_r  <= '0;
      clr_item_r  <= 1'b0;
      pend_en_r   <= 1'b0;
      page_r      <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      clr_addr_r  <= clr_addr_nxt;
      clr_item_r  <= clr_item_nxt;
      pend_en_r   <= pend_en_nxt;
      page_r      <= page_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r  <= pfb_pkg::func_t'(in_bus.func);
      x_r     <= in_bus.pos_x;
      y_r     <= in_bus.pos_y;
      color_r <= in_bus.color;
      pat_r   <= in_bus.pattern;
      cnt_r   <= (in_bus.bit_count > 4'(pfb_pkg::BITS_PER_BEAT)) ?
                 4'(pfb_pkg::BITS_PER_BEAT) : in_bus.bit_count;
    end
    pend_addr_r <= loc.addr;
    pend_mask_r <= loc.mask;
    pend_set_r  <= (func_r == pfb_pkg::FN_PIXEL) ? color_r : 1'b1;
    res_byte_r  <= res_byte_nxt;
    res_data_r  <= res_data_nxt;
    res_end_r   <= res_end_nxt;
    if (load_out) begin
      out_byte_r <= res_byte_r;
      out_data_r <= res_data_r;
      out_end_r  <= res_end_r;
    end
  end

  `PFB_ASSERT_NOW(a_pend_in_rmw, pend_en_r, (state_r == S_TAIL || state_r == S_RMW) && (32'(pend_addr_r) < 32'(pfb_pkg::STORE_BYTES)), "pending write outside read-modify-write")
  `PFB_ASSERT_NOW(a_flush_range, 1'b1, (32'(pos_r) < 32'(pfb_pkg::HEADER_LEN + pfb_pkg::COLUMNS)) && (32'(page_r) < 32'(pfb_pkg::PAGES)), "flush position out of range")
  `PFB_ASSERT_NOW(a_out_from_done, $rose(out_valid_r), $past(state_r) == S_DONE, "result beat not from done state")
  `PFB_ASSERT_NEXT(a_flush_start, accept && (in_bus.func == pfb_pkg::FN_FLUSH), state_r == S_FLUSH, "flush step not started")

endmodule

FILE: dv/page_framebuffer_blit_flush_unit_test.sv
// testbench of the page framebuffer blit and flush unit: directed table, then random items
module page_framebuffer_blit_flush_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT  = 4000;
  localparam int TAIL_CYCLES  = 16;
  localparam int PHASE_ITEMS  = 142;

  typedef struct packed {
    pfb_pkg::func_t func;
    logic [7:0]     pos_x;
    logic [7:0]     pos_y;
    logic           color;
    logic [7:0]     pattern;
    logic [3:0]     bit_count;
  } draw_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_data;
    logic       frame_end;
  } stream_beat_t;

  typedef struct packed {
    draw_item_t   item;
    logic         typed;
    stream_beat_t want;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst_n;

  pfb_in_if  in_ch ();
  pfb_out_if out_ch ();

  page_framebuffer_blit_flush_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_ch),
    .out_bus (out_ch)
  );

  always #10 clk = ~clk;

  logic [7:0]   shadow_store [pfb_pkg::STORE_BYTES];
  int           shadow_page;
  int           shadow_pos;
  stream_beat_t pending_beats [$];

  int errors;
  int items_sent;
  int clears_sent;
  int beats_checked;
  int frames_seen;
  int stall_cycles;
  int send_idle_pct;
  int recv_idle_pct;

  // no beat on the drawing functions carries anything but zero
  directed_row_t directed_rows [23] = '{
    '{'{pfb_pkg::FN_FLUSH, 8'h00, 8'h00, 1'b0, 8'h00, 4'h0}, 1'b1,
      '{pfb_pkg::CMD_PAGE_BASE, 1'b0, 1'b0}},
    '{'{pfb_pkg::FN_FLUSH, 8'hFF, 8'hFF, 1'b1, 8'hFF, 4'hF}, 1'b1,
      '{pfb_pkg::CMD_COL_LOW, 1'b0, 1'b0}},
    '{'{pfb_pkg::FN_FLUSH, 8'h00, 8'h00, 1'b0, 8'h00, 4'h0}, 1'b1,
      '{pfb_pkg::CMD_COL_HIGH, 1'b0, 1'b0}},
    '{'{pfb_pkg::FN_FLUSH, 8'h00, 8'h00, 1'b0, 8'h00, 4'h0}, 1'b1, '{8'h00, 1'b1, 1'b0}},
    '{'{pfb_pkg::FN_PIXEL, 8'd1, 8'd0, 1'b1, 8'h00, 4'h0}, 1'b1, '0},
    '{'{pfb_pkg::FN_FLUSH, 8'h00, 8'h00, 1'b0, 8'h00, 4'h0}, 1'b0, '0},
    '{'{pfb_pkg::FN_PIXEL, 8'd255, 8'd255, 1'b1, 8'h00, 4'h0}, 1'b1, '0},
    '{'{pfb_pkg::FN_PIXEL, 8'd127, 8'd31, 1'b1, 8'h00, 4'h0}, 1'b1, '0},
    '{'{pfb_pkg::FN_PIXEL, 8'd128, 8'd0, 1'b1, 8'h00, 4'h0}, 1'b1, '0},
    '{'{pfb_pkg::FN_PIXEL, 8'd0, 8'd32, 1'b1, 8'h00, 4'h0}, 1'b1, '0},
    '{'{pfb_pkg::FN_BLIT, 8'd2, 8'd0, 1'b0, 8'hFF, 4'd8}, 1'b1, '0},
    '{'{pfb_pkg::FN_FLUSH, 8'h00, 8'h00, 1'b0, 8'h00, 4'h0}, 1'b0, '0},
    '{'{pfb_pkg::FN_BLIT, 8'd124, 8'd7, 1'b0, 8'hFF, 4'd15}, 1'b1, '0},
    '{'{pfb_pkg::FN_BLIT, 8'd10, 8'd0, 1'b0, 8'hAA, 4'd0}, 1'b1, '0},
    '{'{pfb_pkg::FN_BLIT, 8'd20, 8'd1, 1'b0, 8'h81, 4'd3}, 1'b1, '0},
    '{'{pfb_pkg::FN_PIXEL, 8'd2, 8'd0, 1'b0, 8'h00, 4'h0}, 1'b1, '0},
    '{'{pfb_pkg::FN_FLUSH, 8'h00, 8'h00, 1'b0, 8'h00, 4'h0}, 1'b0, '0},
    '{'{pfb_pkg::FN_CLEAR, 8'hFF, 8'hFF, 1'b1, 8'hFF, 4'hF}, 1'b1, '0},
    '{'{pfb_pkg::FN_FLUSH, 8'h00, 8'h00, 1'b0, 8'h00, 4'h0}, 1'b0, '0},
    '{'{pfb_pkg::FN_BLIT, 8'd255, 8'd0, 1'b0, 8'hFF, 4'd8}, 1'b1, '0},
    '{'{pfb_pkg::FN_PIXEL, 8'd5, 8'd3, 1'b1, 8'hFF, 4'hF}, 1'b1, '0},
    '{'{pfb_pkg::FN_BLIT, 8'd0, 8'd255, 1'b1, 8'h5A, 4'd8}, 1'b1, '0},
    '{'{pfb_pkg::FN_FLUSH, 8'h00, 8'h00, 1'b0, 8'h00, 4'h0}, 1'b0, '0}
  };

  function automatic void plot_pixel(input int x, input int y, input logic on);
    int idx;
    if (x >= pfb_pkg::COLUMNS || y >= pfb_pkg::ROWS) return;
    idx = (y / 8) * pfb_pkg::COLUMNS + x;
    if (on) shadow_store[idx][y % 8] = 1'b1;
    else shadow_store[idx][y % 8] = 1'b0;
  endfunction

  function automatic stream_beat_t framebuffer_response(input draw_item_t it);
    stream_beat_t r;
    int           cnt;
    r = '0;
    case (it.func)
      pfb_pkg::FN_CLEAR: begin
        foreach (shadow_store[i]) shadow_store[i] = 8'h00;
      end
      pfb_pkg::FN_PIXEL: begin
        plot_pixel(it.pos_x, it.pos_y, it.color);
      end
      pfb_pkg::FN_BLIT: begin
        cnt = (it.bit_count > 8) ? 8 : int'(it.bit_count);
        for (int i = 0; i < cnt; i++) begin
          if (it.pattern[7 - i]) plot_pixel(int'(it.pos_x) + i, it.pos_y, 1'b1);
        end
      end
      default: begin
        if (shadow_page >= pfb_pkg::PAGES) shadow_page = 0;
        if (shadow_pos == 0) begin
          r.out_byte = pfb_pkg::CMD_PAGE_BASE + 8'(shadow_page);
        end else if (shadow_pos == 1) begin
          r.out_byte = pfb_pkg::CMD_COL_LOW;
        end else if (shadow_pos == 2) begin
          r.out_byte = pfb_pkg::CMD_COL_HIGH;
        end else begin
          r.out_byte = shadow_store[shadow_page * pfb_pkg::COLUMNS + shadow_pos -
                                    pfb_pkg::HEADER_LEN];
          r.is_data = 1'b1;
        end
        shadow_pos++;
        if (shadow_pos >= pfb_pkg::HEADER_LEN + pfb_pkg::COLUMNS) begin
          shadow_pos = 0;
          shadow_page++;
          if (shadow_page >= pfb_pkg::PAGES) begin
            shadow_page = 0;
            r.frame_end = 1'b1;
          end
        end
      end
    endcase
    return r;
  endfunction

  function automatic draw_item_t random_item();
    draw_item_t it;
    int         roll;
    roll = $urandom_range(99);
    if (roll < 1) it.func = pfb_pkg::FN_CLEAR;
    else if (roll < 11) it.func = pfb_pkg::FN_PIXEL;
    else if (roll < 21) it.func = pfb_pkg::FN_BLIT;
    else it.func = pfb_pkg::FN_FLUSH;
    // mostly on the panel, the rest anywhere in the field
    it.pos_x = ($urandom_range(99) < 75) ? 8'($urandom_range(pfb_pkg::COLUMNS - 1))
                                         : 8'($urandom_range(255));
    it.pos_y = ($urandom_range(99) < 75) ? 8'($urandom_range(pfb_pkg::ROWS - 1))
                                         : 8'($urandom_range(255));
    it.color = 1'($urandom_range(1));
    it.pattern = 8'($urandom_range(255));
    it.bit_count = ($urandom_range(99) < 80) ? 4'($urandom_range(8, 1))
                                             : 4'($urandom_range(15));
    return it;
  endfunction

  task automatic push_item(input draw_item_t it, input logic typed, input stream_beat_t want);
    stream_beat_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.func      <= it.func;
    in_ch.pos_x     <= it.pos_x;
    in_ch.pos_y     <= it.pos_y;
    in_ch.color     <= it.color;
    in_ch.pattern   <= it.pattern;
    in_ch.bit_count <= it.bit_count;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predicted = framebuffer_response(it);
    pending_beats.push_back(typed ? want : predicted);
    items_sent++;
    if (it.func == pfb_pkg::FN_CLEAR) clears_sent++;
  endtask

  task automatic report_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    stream_beat_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_beats.size() == 0) begin
        $display("%0t: beat with nothing expected, expected none, actual %h/%b/%b", $time,
                 out_ch.out_byte, out_ch.is_data, out_ch.frame_end);
        errors++;
      end else begin
        want = pending_beats.pop_front();
        report_field("out_byte", want.out_byte, out_ch.out_byte);
        report_field("is_data", want.is_data, out_ch.is_data);
        report_field("frame_end", want.frame_end, out_ch.frame_end);
      end
      beats_checked++;
      if (out_ch.frame_end) frames_seen++;
    end
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
        $display("TEST FAILED");
        $finish;
      end
    end
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin
    errors = 0;
    items_sent = 0;
    clears_sent = 0;
    beats_checked = 0;
    frames_seen = 0;
    stall_cycles = 0;
    send_idle_pct = 27;
    recv_idle_pct = 52;
    foreach (shadow_store[i]) shadow_store[i] = 8'h00;
    shadow_page = 0;
    shadow_pos = 0;
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.func      <= pfb_pkg::FN_CLEAR;
    in_ch.pos_x     <= 8'h00;
    in_ch.pos_y     <= 8'h00;
    in_ch.color     <= 1'b0;
    in_ch.pattern   <= 8'h00;
    in_ch.bit_count <= 4'h0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      push_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
    end

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 27 : (ph == 1) ? 52 : 0;
      recv_idle_pct = (ph == 0) ? 52 : (ph == 1) ? 27 : 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        push_item(random_item(), 1'b0, '0);
      end
    end
    in_ch.valid <= 1'b0;

    while (pending_beats.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d items (%0d clears) under three idling mixes", items_sent, clears_sent);
    $display("checked %0d stream beats, %0d full frames flushed", beats_checked, frames_seen);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
